>>> src/skt_pkg.sv
`default_nettype none

package skt_pkg;

   // table geometry
   localparam int DEPTH      = 64;
   localparam int VALUE_BITS = 16;
   localparam int KEY_BYTES  = 7;
   localparam int KEY_BITS   = 8 * KEY_BYTES;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int CMD_BITS   = 2;
   localparam int STAT_BITS  = 3;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0]   index_type;

   // request commands
   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   // response status codes
   typedef enum logic [STAT_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_ROTATE = 2'd2,
      OP_LOOKUP = 2'd3
   } cell_op_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_LOOK = 2'd2,
      S_DUMP = 2'd3
   } state_type;

   // one stored entry
   typedef struct packed {
      key_type   key;
      value_type value;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
      count_type   count;
   } cell_ctrl_type;

   function automatic logic byte_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
             (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic key_valid(input key_type key);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         ok = ok & byte_alnum(key[8*i +: 8]);
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

>>> src/skt_if.sv
`default_nettype none

// request channel
interface skt_req_if;
   logic                      valid;
   logic                      ready;
   logic [skt_pkg::CMD_BITS-1:0] cmd;
   skt_pkg::key_type          key;
   skt_pkg::value_type        value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// response channel
interface skt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [skt_pkg::STAT_BITS-1:0] status;
   skt_pkg::key_type              found_key;
   skt_pkg::value_type            found_value;
   skt_pkg::count_type            entry_count;
   logic                          last;

   modport source (output valid, output status, output found_key, output found_value,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input found_key, input found_value,
                   input entry_count, input last, output ready);
endinterface

`default_nettype wire

>>> src/sorted_key_table.sv
// sorted key table: up to DEPTH entries of a 7-byte key and a value handle,
// held in ascending key order in a row of cells.
// req_ch carries cmd, key and value; rsp_ch carries status, found_key,
// found_value, entry_count and last. Both use valid/ready, a word moving on
// an edge where both are high.
// insert: the key is checked for letters and digits, then every cell
// compares in parallel and the upper part of the row shifts up by one;
// one response.
// lookup: the cells register a flag on the first equal key and the flagged
// value is then selected into the response; one response.
// dump: the occupied cells rotate one place a cycle while the response can
// be loaded and cell zero is sent each time, so n entries give n responses;
// an empty table gives one response with status empty.
// one request is worked at a time; a new one is taken as soon as the
// previous response sits in the output register, even if not yet taken.
// a stalled receiver holds the response and the controller waits for it.
// reset clears the fill count and the controller; entry storage is not
// cleared and needs no clearing pass.
`default_nettype none

module sorted_key_table (
   input  wire logic  clock,
   input  wire logic  reset,
   skt_req_if.sink    req_ch,
   skt_rsp_if.source  rsp_ch
);

   localparam int N = skt_pkg::DEPTH;

   skt_pkg::state_type  state_ff, state_in;
   skt_pkg::count_type  count_ff, count_in;
   skt_pkg::count_type  rot_ff, rot_in;
   logic [skt_pkg::CMD_BITS-1:0] cmd_ff, cmd_in;
   skt_pkg::entry_type  word_ff, word_in;

   logic                rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type rsp_status_ff, rsp_status_in;
   skt_pkg::key_type    rsp_key_ff, rsp_key_in;
   skt_pkg::value_type  rsp_value_ff, rsp_value_in;
   skt_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   skt_pkg::cell_ctrl_type ctrl;
   skt_pkg::cell_op_type   op;
   skt_pkg::entry_type     cell_entry [N];
   logic [N-1:0]           cell_lt;
   logic [N-1:0]           cell_hit;
   skt_pkg::value_type     hit_value;
   logic                   out_free, load, dump_last, accept;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == skt_pkg::S_IDLE);
   assign dump_last = (rot_ff == (count_ff - 1'b1));

   // broadcast to the cells
   assign ctrl.op        = op;
   assign ctrl.new_entry = word_ff;
   assign ctrl.count     = count_ff;

   // row of cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      skt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (skt_pkg::IDX_BITS'(i)),
         .prev_entry ((i == 0) ? cell_entry[0] : cell_entry[(i == 0) ? 0 : i-1]),
         .prev_lt    ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i-1]),
         .next_entry ((i == N-1) ? cell_entry[0] : cell_entry[(i == N-1) ? 0 : i+1]),
         .head_entry (cell_entry[0]),
         .entry      (cell_entry[i]),
         .lt         (cell_lt[i]),
         .hit        (cell_hit[i])
      );
   end

   // select the flagged value, at most one cell is flagged
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < N; i++) begin
         hit_value = hit_value | (cell_hit[i] ? cell_entry[i].value : '0);
      end
   end

   // controller
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rot_in        = rot_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      op            = skt_pkg::OP_HOLD;
      load          = 1'b0;
      rsp_status_in = skt_pkg::ST_OK;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in        = req_ch.cmd;
               word_in.key   = req_ch.key;
               word_in.value = req_ch.value;
               state_in      = skt_pkg::S_EXEC;
            end
         end
         skt_pkg::S_EXEC: begin
            case (cmd_ff)
               skt_pkg::CMD_INSERT: begin
                  if (out_free) begin
                     load     = 1'b1;
                     state_in = skt_pkg::S_IDLE;
                     if (!skt_pkg::key_valid(word_ff.key)) begin
                        rsp_status_in = skt_pkg::ST_INVALID;
                     end else if (count_ff == skt_pkg::COUNT_BITS'(N)) begin
                        rsp_status_in = skt_pkg::ST_FULL;
                     end else begin
                        op       = skt_pkg::OP_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               skt_pkg::CMD_LOOKUP: begin
                  op       = skt_pkg::OP_LOOKUP;
                  state_in = skt_pkg::S_LOOK;
               end
               skt_pkg::CMD_DUMP: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        load          = 1'b1;
                        rsp_status_in = skt_pkg::ST_EMPTY;
                        state_in      = skt_pkg::S_IDLE;
                     end
                  end else begin
                     rot_in   = '0;
                     state_in = skt_pkg::S_DUMP;
                  end
               end
               default: begin
                  state_in = skt_pkg::S_IDLE;
               end
            endcase
         end
         skt_pkg::S_LOOK: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = skt_pkg::S_IDLE;
               if (|cell_hit) begin
                  rsp_key_in   = word_ff.key;
                  rsp_value_in = hit_value;
               end else begin
                  rsp_status_in = skt_pkg::ST_NOTFOUND;
               end
            end
         end
         skt_pkg::S_DUMP: begin
            if (out_free) begin
               load         = 1'b1;
               op           = skt_pkg::OP_ROTATE;
               rsp_key_in   = cell_entry[0].key;
               rsp_value_in = cell_entry[0].value;
               rsp_last_in  = dump_last;
               rot_in       = rot_ff + 1'b1;
               if (dump_last) begin
                  state_in = skt_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = skt_pkg::S_IDLE;
         end
      endcase
      rsp_count_in = count_in;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output words
   always_ff @(posedge clock) begin
      rot_ff  <= rot_in;
      cmd_ff  <= cmd_in;
      word_ff <= word_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found_key   = rsp_key_ff;
   assign rsp_ch.found_value = rsp_value_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // fill level never passes the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::COUNT_BITS'(N))
      else $error("fill count beyond table size");

   // fill level only ever steps up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == skt_pkg::COUNT_BITS'($past(count_ff) + 1'b1)))
      else $error("fill count moved by other than one");

   // at most one cell claims the lookup
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_LOOK) |-> $onehot0(cell_hit))
      else $error("several cells flagged on lookup");

   // a dump ends with the last entry sent
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_DUMP && load && dump_last) |=>
         (state_ff == skt_pkg::S_IDLE && rsp_last_ff))
      else $error("dump did not finish on last entry");

endmodule

`default_nettype wire

>>> src/skt_cell.sv
`default_nettype none

module skt_cell (
   input  wire logic                   clock,
   input  wire skt_pkg::cell_ctrl_type ctrl,
   input  wire skt_pkg::index_type     cell_index,
   input  wire skt_pkg::entry_type     prev_entry,
   input  wire logic                   prev_lt,
   input  wire skt_pkg::entry_type     next_entry,
   input  wire skt_pkg::entry_type     head_entry,
   output skt_pkg::entry_type          entry,
   output logic                        lt,
   output logic                        hit
);

   skt_pkg::entry_type entry_ff, entry_in;
   logic               hit_ff, hit_in;
   logic               occupied, at_end, eq;

   // position of this cell against the fill level
   assign occupied = skt_pkg::COUNT_BITS'(cell_index) < ctrl.count;
   assign at_end   = skt_pkg::COUNT_BITS'(cell_index) == (ctrl.count - 1'b1);

   // key compares against the broadcast key
   assign lt = occupied && (entry_ff.key < ctrl.new_entry.key);
   assign eq = occupied && (entry_ff.key == ctrl.new_entry.key);

   // next entry: hold, take the new word, shift up, or rotate down
   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      case (ctrl.op)
         skt_pkg::OP_INSERT: begin
            if (!lt) begin
               entry_in = prev_lt ? ctrl.new_entry : prev_entry;
            end
         end
         skt_pkg::OP_ROTATE: begin
            if (at_end) begin
               entry_in = head_entry;
            end else if (occupied) begin
               entry_in = next_entry;
            end
         end
         skt_pkg::OP_LOOKUP: begin
            // first equal entry: the one below it is smaller
            hit_in = eq && prev_lt;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire
